[design/dnh_pkg.sv]
package dnh_pkg;

   localparam int unsigned MAX_NAME_BYTES = 255;

   localparam logic [31:0] TEA_GOLDEN    = 32'h9E37_79B9;
   localparam logic [31:0] MD4_K2        = 32'h5A82_7999;
   localparam logic [31:0] MD4_K3        = 32'h6ED9_EBA1;
   localparam logic [31:0] LEG_INIT_CUR  = 32'h12A3_FE2D;
   localparam logic [31:0] LEG_INIT_PREV = 32'h37AB_E8F9;
   localparam logic [31:0] LEG_MULT      = 32'd7152373;
   localparam logic [31:0] LEG_FOLD      = 32'h7FFF_FFFF;
   localparam logic [31:0] MAJOR_END     = 32'hFFFF_FFFE;
   localparam logic [31:0] MAJOR_REMAP   = 32'hFFFF_FFFC;

   localparam logic [3:0][31:0] MD4_INIT = {32'h1032_5476, 32'h98BA_DCFE,
                                            32'hEFCD_AB89, 32'h6745_2301};

   // hash families
   localparam logic [1:0] KIND_LEGACY = 2'd0;
   localparam logic [1:0] KIND_MD4    = 2'd1;
   localparam logic [1:0] KIND_TEA    = 2'd2;

   localparam logic [2:0] VER_LAST_VALID = 3'd5;
   localparam logic [2:0] VER_FIRST_UNSIGNED = 3'd3;

   // register indexes
   localparam logic [2:0] CSR_VERSION = 3'd0;
   localparam logic [2:0] CSR_SEED0   = 3'd1;
   localparam logic [2:0] CSR_SEED1   = 3'd2;
   localparam logic [2:0] CSR_SEED2   = 3'd3;
   localparam logic [2:0] CSR_SEED3   = 3'd4;

   localparam logic [2:0] VER_RESET = 3'd1;

   typedef struct packed {
      logic              start;
      logic              do_block;
      logic              emit;
      logic [2:0]        version;
      logic [31:0]       legacy_hash;
      logic [7:0][31:0]  words;
      logic [3:0][31:0]  init;
   } job_type;

   typedef struct packed {
      logic [31:0] major_hash;
      logic [31:0] minor_digest;
      logic        status;
   } result_type;

   function automatic logic [1:0] ver_kind(input logic [2:0] v);
      logic [1:0] k;
      case (v)
         3'd0, 3'd3, 3'd6: k = KIND_LEGACY;
         3'd1, 3'd4, 3'd7: k = KIND_MD4;
         default:          k = KIND_TEA;
      endcase
      return k;
   endfunction

   function automatic logic [2:0] md4_word(input logic [4:0] k);
      logic [2:0] w;
      case (k[4:3])
         2'd0:    w = k[2:0];
         2'd1:    w = {k[1:0], 1'b1} + {k[2], 2'b00} - 3'd0;
         default: begin
            case (k[2:0])
               3'd0: w = 3'd3;
               3'd1: w = 3'd7;
               3'd2: w = 3'd2;
               3'd3: w = 3'd6;
               3'd4: w = 3'd1;
               3'd5: w = 3'd5;
               3'd6: w = 3'd0;
               default: w = 3'd4;
            endcase
         end
      endcase
      // second round order is 1,3,5,7,0,2,4,6
      if (k[4:3] == 2'd1) begin
         w = k[2] ? {k[1:0], 1'b0} : {k[1:0], 1'b1};
      end
      return w;
   endfunction

   function automatic logic [4:0] md4_shift(input logic [4:0] k);
      logic [4:0] s;
      case ({k[4:3], k[1:0]})
         4'b0000: s = 5'd3;
         4'b0001: s = 5'd7;
         4'b0010: s = 5'd11;
         4'b0011: s = 5'd19;
         4'b0100: s = 5'd3;
         4'b0101: s = 5'd5;
         4'b0110: s = 5'd9;
         4'b0111: s = 5'd13;
         4'b1000: s = 5'd3;
         4'b1001: s = 5'd9;
         4'b1010: s = 5'd11;
         default: s = 5'd15;
      endcase
      return s;
   endfunction

   function automatic logic [1:0] md4_target(input logic [1:0] k);
      return 2'd0 - k;
   endfunction

   function automatic logic [31:0] pad_word(input logic [7:0] len, input logic [7:0] start);
      logic [7:0] r;
      r = len - start;
      return {r, r, r, r};
   endfunction

endpackage

[design/dnh_job_queue.sv]
module dnh_job_queue
   import dnh_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output job_type pop_data
);

   job_type    mem_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full     = cnt_ff == 2'd2;
   assign empty    = cnt_ff == 2'd0;
   assign pop_data = mem_ff[rd_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_in  = do_push ? !wr_ff : wr_ff;
      rd_in  = do_pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

[design/dnh_rsp_queue.sv]
module dnh_rsp_queue
   import dnh_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       full,
   input  logic       pop,
   output logic       empty,
   output result_type pop_data
);

   result_type mem_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full     = cnt_ff == 2'd2;
   assign empty    = cnt_ff == 2'd0;
   assign pop_data = mem_ff[rd_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_in  = do_push ? !wr_ff : wr_ff;
      rd_in  = do_pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

[design/dnh_front.sv]
module dnh_front
   import dnh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_write_data,
   input  logic        accept,
   input  logic [7:0]  name_byte,
   input  logic [7:0]  name_length,
   input  logic        last_byte,
   output logic        job_push,
   output job_type     job
);

   logic [2:0]        hv_ff;
   logic [3:0][31:0]  seed_ff;
   logic [7:0]        bytes_ff, bytes_in;
   logic [31:0]       partial_ff, partial_in;
   logic [7:0][31:0]  words_ff, words_in;
   logic [2:0]        ver_ff, ver_in;
   logic [3:0][31:0]  init_ff, init_in;
   logic [31:0]       cur_ff, cur_in, prev_ff, prev_in;
   logic              loaded_ff, loaded_in;

   logic [7:0]        len, bytes0, bytes1, start0, start1;
   logic              empty_name, first, absorb, last, blk_done, sgn;
   logic [2:0]        ver;
   logic [1:0]        kind;
   logic [3:0][31:0]  init;
   logic [31:0]       cur0, prev0, cur1, partial0, partial1, val, h, pw_base, pw_new, pad_f;
   logic [7:0][31:0]  words1, fin_words;
   logic [4:0]        mask, j, fill;
   logic              loaded0;

   always_comb begin
      len        = (name_length > 8'(MAX_NAME_BYTES)) ? 8'(MAX_NAME_BYTES) : name_length;
      empty_name = len == 8'd0;
      first      = empty_name || bytes_ff == 8'd0;
      ver        = first ? hv_ff : ver_ff;
      init       = init_ff;
      if (first) begin
         init = (|seed_ff) ? seed_ff : MD4_INIT;
      end
      kind     = ver_kind(ver);
      sgn      = ver < VER_FIRST_UNSIGNED;
      cur0     = empty_name ? LEG_INIT_CUR : cur_ff;
      prev0    = empty_name ? LEG_INIT_PREV : prev_ff;
      bytes0   = empty_name ? 8'd0 : bytes_ff;
      partial0 = empty_name ? 32'd0 : partial_ff;
      loaded0  = empty_name ? 1'b0 : loaded_ff;
      absorb   = !empty_name && bytes0 < len;
      val      = {(sgn && name_byte[7]) ? 24'hFF_FFFF : 24'd0, name_byte};

      // legacy step
      h = prev0 + (cur0 ^ (val * LEG_MULT));
      if (h[31]) begin
         h = h - LEG_FOLD;
      end

      // block packing, first byte in the high end of each word
      mask    = (kind == KIND_MD4) ? 5'd31 : 5'd15;
      j       = bytes0[4:0] & mask;
      start0  = bytes0 - {3'd0, j};
      pw_base = (j[1:0] == 2'd0) ? pad_word(len, start0) : partial0;
      pw_new  = (pw_base << 8) + val;

      cur1     = cur0;
      partial1 = partial0;
      words1   = words_ff;
      bytes1   = bytes0;
      blk_done = 1'b0;
      if (absorb) begin
         bytes1 = bytes0 + 8'd1;
         if (kind == KIND_LEGACY) begin
            cur1 = h;
         end else begin
            partial1 = pw_new;
            if (j[1:0] == 2'd3) begin
               words1[j[4:2]] = pw_new;
            end
            blk_done = j == mask;
         end
      end

      // tail block for the end of the name
      fill      = bytes1[4:0] & mask;
      start1    = bytes1 - {3'd0, fill};
      pad_f     = pad_word(len, start1);
      fin_words = words1;
      if (fill != 5'd0) begin
         for (int i = 0; i < 8; i++) begin
            if (3'(i) == fill[4:2]) begin
               fin_words[i] = (fill[1:0] != 2'd0) ? partial1 : pad_f;
            end else if (3'(i) > fill[4:2] && (kind == KIND_MD4 || i < 4)) begin
               fin_words[i] = pad_f;
            end
         end
      end

      last             = last_byte || empty_name;
      job.start        = !loaded0;
      job.emit         = last;
      job.do_block     = kind != KIND_LEGACY && (blk_done || (last && fill != 5'd0));
      job.version      = ver;
      job.legacy_hash  = cur1;
      job.words        = last ? fin_words : words1;
      job.init         = init;
      job_push         = accept && (blk_done || last);

      bytes_in   = bytes_ff;
      partial_in = partial_ff;
      words_in   = words_ff;
      ver_in     = ver_ff;
      init_in    = init_ff;
      cur_in     = cur_ff;
      prev_in    = prev_ff;
      loaded_in  = loaded_ff;
      if (accept) begin
         words_in = words1;
         if (last) begin
            bytes_in   = 8'd0;
            partial_in = 32'd0;
            cur_in     = LEG_INIT_CUR;
            prev_in    = LEG_INIT_PREV;
            loaded_in  = 1'b0;
         end else begin
            bytes_in   = bytes1;
            partial_in = partial1;
            cur_in     = cur1;
            prev_in    = (absorb && kind == KIND_LEGACY) ? cur0 : prev0;
            loaded_in  = loaded0 || blk_done;
            ver_in     = ver;
            init_in    = init;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hv_ff     <= VER_RESET;
         seed_ff   <= '0;
         bytes_ff  <= 8'd0;
         partial_ff <= 32'd0;
         ver_ff    <= VER_RESET;
         cur_ff    <= LEG_INIT_CUR;
         prev_ff   <= LEG_INIT_PREV;
         loaded_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_VERSION: hv_ff      <= csr_write_data[2:0];
               CSR_SEED0:   seed_ff[0] <= csr_write_data;
               CSR_SEED1:   seed_ff[1] <= csr_write_data;
               CSR_SEED2:   seed_ff[2] <= csr_write_data;
               CSR_SEED3:   seed_ff[3] <= csr_write_data;
               default: ;
            endcase
         end
         bytes_ff   <= bytes_in;
         partial_ff <= partial_in;
         ver_ff     <= ver_in;
         cur_ff     <= cur_in;
         prev_ff    <= prev_in;
         loaded_ff  <= loaded_in;
      end
   end

   always_ff @(posedge clock) begin
      words_ff <= words_in;
      init_ff  <= init_in;
   end

endmodule

[design/dnh_back.sv]
module dnh_back
   import dnh_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       job_empty,
   input  job_type    job,
   output logic       job_pop,
   input  logic       res_full,
   output logic       res_push,
   output result_type res
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ROUND = 2'd1;
   localparam logic [1:0] ST_ADD   = 2'd2;
   localparam logic [1:0] ST_FIN   = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [4:0]        cnt_ff, cnt_in;
   job_type           job_ff, job_in;
   logic [3:0][31:0]  chain_ff, chain_in, v_ff, v_in, chain0;
   logic [31:0]       sum_ff, sum_in;
   logic [1:0]        kind, t;
   logic [31:0]       x, y, z, f, add, acc, rot, sn, w0, w1, w2, w3, major;
   logic [4:0]        s;
   logic              round_last;

   always_comb begin
      kind = ver_kind(job_ff.version);

      // one MD4 step
      t = md4_target(cnt_ff[1:0]);
      x = v_ff[t + 2'd1];
      y = v_ff[t + 2'd2];
      z = v_ff[t + 2'd3];
      case (cnt_ff[4:3])
         2'd0: begin
            f   = z ^ (x & (y ^ z));
            add = 32'd0;
         end
         2'd1: begin
            f   = (x & y) + ((x ^ y) & z);
            add = MD4_K2;
         end
         default: begin
            f   = x ^ y ^ z;
            add = MD4_K3;
         end
      endcase
      acc = v_ff[t] + f + job_ff.words[md4_word(cnt_ff)] + add;
      s   = md4_shift(cnt_ff);
      rot = (acc << s) | (acc >> (6'd32 - {1'b0, s}));

      w0 = job_ff.words[0];
      w1 = job_ff.words[1];
      w2 = job_ff.words[2];
      w3 = job_ff.words[3];
      sn = sum_ff + TEA_GOLDEN;

      round_last = (kind == KIND_MD4) ? cnt_ff == 5'd23 : cnt_ff == 5'd31;

      // result from the chain, or from the legacy hash for legacy versions
      res.status     = job_ff.version > VER_LAST_VALID;
      case (kind)
         KIND_MD4: begin
            major            = chain_ff[1];
            res.minor_digest = chain_ff[2];
         end
         KIND_TEA: begin
            major            = chain_ff[0];
            res.minor_digest = chain_ff[1];
         end
         default: begin
            major            = job_ff.legacy_hash << 1;
            res.minor_digest = 32'd0;
         end
      endcase
      major = major & ~32'd1;
      if (major == MAJOR_END) begin
         major = MAJOR_REMAP;
      end
      res.major_hash = major;
      if (res.status) begin
         res.major_hash   = 32'd0;
         res.minor_digest = 32'd0;
      end

      chain0   = job.start ? job.init : chain_ff;
      state_in = state_ff;
      cnt_in   = cnt_ff;
      job_in   = job_ff;
      chain_in = chain_ff;
      v_in     = v_ff;
      sum_in   = sum_ff;
      job_pop  = 1'b0;
      res_push = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!job_empty) begin
               job_pop  = 1'b1;
               job_in   = job;
               chain_in = chain0;
               v_in     = chain0;
               sum_in   = 32'd0;
               cnt_in   = 5'd0;
               state_in = job.do_block ? ST_ROUND : ST_FIN;
            end
         end
         ST_ROUND: begin
            if (kind == KIND_MD4) begin
               v_in[t] = rot;
            end else if (!cnt_ff[0]) begin
               sum_in  = sn;
               v_in[0] = v_ff[0] + (((v_ff[1] << 4) + w0) ^ (v_ff[1] + sn)
                                    ^ ((v_ff[1] >> 5) + w1));
            end else begin
               v_in[1] = v_ff[1] + (((v_ff[0] << 4) + w2) ^ (v_ff[0] + sum_ff)
                                    ^ ((v_ff[0] >> 5) + w3));
            end
            cnt_in = cnt_ff + 5'd1;
            if (round_last) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            chain_in[0] = chain_ff[0] + v_ff[0];
            chain_in[1] = chain_ff[1] + v_ff[1];
            if (kind == KIND_MD4) begin
               chain_in[2] = chain_ff[2] + v_ff[2];
               chain_in[3] = chain_ff[3] + v_ff[3];
            end
            state_in = ST_FIN;
         end
         default: begin
            if (!job_ff.emit) begin
               state_in = ST_IDLE;
            end else if (!res_full) begin
               res_push = 1'b1;
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= 5'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff   <= job_in;
      chain_ff <= chain_in;
      v_ff     <= v_in;
      sum_ff   <= sum_in;
   end

endmodule

[design/directory_name_hash_top.sv]
// Channel   Direction  Handshake                     Transaction
// req_      in         push / full                   one name byte, its length, end flag
// rsp_      out        empty / pop                   major hash, minor hash, status
// csr_      in         write_enable, no wait         version or one of four seed words
//
// Bytes are taken at one per cycle while the job queue has room; the front packs
// words and runs the legacy hash in place. Each full block and each name end go to
// the back unit, which takes the job, runs the half-MD4 or TEA rounds on a block,
// folds the round state into the chain and posts the result at a name end. The
// front keeps taking bytes while the back works, until the job queue fills.
// Reset is synchronous and loads version 1 with a zero seed. The input stalls only
// on a full job queue; the result queue holds two results while pop is low.
module directory_name_hash_top
   import dnh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_name_byte,
   input  logic [7:0]  req_name_length,
   input  logic        req_last_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_major_hash,
   output logic [31:0] rsp_minor_digest,
   output logic        rsp_status,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_write_data
);

   job_type    fe_job, be_job;
   logic       fe_push, jq_full, jq_empty, be_pop;
   logic       res_push, rq_full;
   result_type be_res, rq_data;
   logic       accept;

   // take a byte only when the job queue cannot overflow
   assign accept   = req_push && !jq_full;
   assign req_full = jq_full;

   dnh_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .accept           (accept),
      .name_byte        (req_name_byte),
      .name_length      (req_name_length),
      .last_byte        (req_last_byte),
      .job_push         (fe_push),
      .job              (fe_job)
   );

   dnh_job_queue u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fe_push),
      .push_data (fe_job),
      .full      (jq_full),
      .pop       (be_pop),
      .empty     (jq_empty),
      .pop_data  (be_job)
   );

   dnh_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (jq_empty),
      .job       (be_job),
      .job_pop   (be_pop),
      .res_full  (rq_full),
      .res_push  (res_push),
      .res       (be_res)
   );

   dnh_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (be_res),
      .full      (rq_full),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .pop_data  (rq_data)
   );

   // hold the oldest result on the ports
   assign rsp_major_hash   = rq_data.major_hash;
   assign rsp_minor_digest = rq_data.minor_digest;
   assign rsp_status       = rq_data.status;

endmodule

[test/tb_directory_name_hash_top.sv]
`timescale 1ns / 1ps

module tb_directory_name_hash_top;
   import dnh_pkg::*;

   // clock and DUT ports
   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [7:0]  req_name_byte;
   logic [7:0]  req_name_length;
   logic        req_last_byte;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [31:0] rsp_major_hash;
   logic [31:0] rsp_minor_digest;
   logic        rsp_status;
   logic        csr_write_enable;
   logic [2:0]  csr_index;
   logic [31:0] csr_write_data;

   directory_name_hash_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_name_byte    (req_name_byte),
      .req_name_length  (req_name_length),
      .req_last_byte    (req_last_byte),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_major_hash   (rsp_major_hash),
      .rsp_minor_digest (rsp_minor_digest),
      .rsp_status       (rsp_status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // 12 ns period
   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // pending hashes, oldest first
   result_type  hash_q[$];
   int          error_count;
   int          names_sent;
   int          bytes_sent;
   int          hashes_seen;
   bit          no_idle;

   // predictor state: registers, latched version and running name state
   logic [2:0]  pv_version;
   logic [31:0] pv_seed [4];
   logic [2:0]  pv_active;
   logic [31:0] pv_chain [4];
   logic [31:0] pv_block [8];
   logic [31:0] pv_partial;
   int          pv_taken;
   logic [31:0] pv_leg_cur;
   logic [31:0] pv_leg_prev;

   function automatic logic [31:0] rotl32(input logic [31:0] x, input int s);
      return (x << s) | (x >> (32 - s));
   endfunction

   function automatic logic [31:0] len_pad(input int len, input int start);
      logic [7:0] r;
      r = 8'((len - start) & 8'hFF);
      return {r, r, r, r};
   endfunction

   task automatic load_chain();
      if ((pv_seed[0] | pv_seed[1] | pv_seed[2] | pv_seed[3]) != 32'd0) begin
         for (int i = 0; i < 4; i++) pv_chain[i] = pv_seed[i];
      end else begin
         for (int i = 0; i < 4; i++) pv_chain[i] = MD4_INIT[i];
      end
   endtask

   task automatic clear_name();
      pv_taken    = 0;
      pv_partial  = 32'd0;
      pv_leg_cur  = LEG_INIT_CUR;
      pv_leg_prev = LEG_INIT_PREV;
   endtask

   // half-MD4 compression of the eight block words into the chain
   task automatic md4_compress();
      logic [31:0] v [4];
      logic [31:0] x, y, z, f, add;
      int t, rnd, i, wi, sh;
      for (int n = 0; n < 4; n++) v[n] = pv_chain[n];
      for (int k = 0; k < 24; k++) begin
         t   = (4 - (k % 4)) % 4;
         rnd = k / 8;
         i   = k % 8;
         x = v[(t + 1) % 4];
         y = v[(t + 2) % 4];
         z = v[(t + 3) % 4];
         if (rnd == 0) begin
            f   = z ^ (x & (y ^ z));
            add = 32'd0;
            wi  = i;
         end else if (rnd == 1) begin
            f   = (x & y) + ((x ^ y) & z);
            add = MD4_K2;
            wi  = (i < 4) ? 2 * i + 1 : 2 * (i - 4);
         end else begin
            f   = x ^ y ^ z;
            add = MD4_K3;
            wi  = (3 - (i >> 1)) + 4 * (i & 1);
         end
         case (rnd * 4 + (k % 4))
            0: sh = 3;   1: sh = 7;   2: sh = 11;  3: sh = 19;
            4: sh = 3;   5: sh = 5;   6: sh = 9;   7: sh = 13;
            8: sh = 3;   9: sh = 9;   10: sh = 11; default: sh = 15;
         endcase
         v[t] = v[t] + f + pv_block[wi] + add;
         v[t] = rotl32(v[t], sh);
      end
      for (int n = 0; n < 4; n++) pv_chain[n] = pv_chain[n] + v[n];
   endtask

   task automatic tea_compress();
      logic [31:0] sum, b0, b1;
      sum = 32'd0;
      b0  = pv_chain[0];
      b1  = pv_chain[1];
      for (int n = 0; n < 16; n++) begin
         sum = sum + TEA_GOLDEN;
         b0 = b0 + (((b1 << 4) + pv_block[0]) ^ (b1 + sum) ^ ((b1 >> 5) + pv_block[1]));
         b1 = b1 + (((b0 << 4) + pv_block[2]) ^ (b0 + sum) ^ ((b0 >> 5) + pv_block[3]));
      end
      pv_chain[0] = pv_chain[0] + b0;
      pv_chain[1] = pv_chain[1] + b1;
   endtask

   task automatic absorb_byte(input logic [7:0] b, input int len);
      logic [1:0]  kind;
      logic [31:0] val, h;
      int bb, j;
      kind = 2'(pv_active % 3);
      val  = {24'd0, b};
      if (pv_active < VER_FIRST_UNSIGNED && b[7]) val[31:8] = 24'hFF_FFFF;
      if (kind == KIND_LEGACY) begin
         h = pv_leg_prev + (pv_leg_cur ^ (val * LEG_MULT));
         if (h[31]) h = h - LEG_FOLD;
         pv_leg_prev = pv_leg_cur;
         pv_leg_cur  = h;
      end else begin
         bb = (kind == KIND_MD4) ? 32 : 16;
         j  = pv_taken % bb;
         if (j % 4 == 0) pv_partial = len_pad(len, pv_taken - j);
         pv_partial = val + (pv_partial << 8);
         if (j % 4 == 3) pv_block[(j >> 2) & 7] = pv_partial;
         if (j == bb - 1) begin
            if (kind == KIND_MD4) md4_compress();
            else tea_compress();
         end
      end
   endtask

   task automatic close_name(input int len, output result_type r);
      logic [1:0]  kind;
      logic [31:0] major, minor, pad;
      int bb, fill, w;
      major = 32'd0;
      minor = 32'd0;
      if (pv_active > VER_LAST_VALID) begin
         r = '{major_hash: 32'd0, minor_digest: 32'd0, status: 1'b1};
         clear_name();
         return;
      end
      kind = 2'(pv_active % 3);
      if (kind == KIND_LEGACY) begin
         major = pv_leg_cur << 1;
      end else begin
         bb   = (kind == KIND_MD4) ? 32 : 16;
         fill = pv_taken % bb;
         if (fill != 0) begin
            pad = len_pad(len, pv_taken - fill);
            w   = fill >> 2;
            pv_block[w & 7] = (fill % 4 != 0) ? pv_partial : pad;
            for (int i = w + 1; i < bb / 4; i++) pv_block[i & 7] = pad;
            if (kind == KIND_MD4) md4_compress();
            else tea_compress();
         end
         if (kind == KIND_MD4) begin
            major = pv_chain[1];
            minor = pv_chain[2];
         end else begin
            major = pv_chain[0];
            minor = pv_chain[1];
         end
      end
      major[0] = 1'b0;
      if (major == MAJOR_END) major = MAJOR_REMAP;
      r = '{major_hash: major, minor_digest: minor, status: 1'b0};
      clear_name();
   endtask

   // advance the predictor by one accepted transaction
   task automatic predict_hash(input logic [7:0] b, input logic [7:0] len_in,
                               input logic last, output bit got, output result_type r);
      int len;
      len = len_in;
      if (len > MAX_NAME_BYTES) len = MAX_NAME_BYTES;
      got = 1'b0;
      r   = '0;
      if (len == 0) begin
         clear_name();
         pv_active = pv_version;
         load_chain();
         close_name(0, r);
         got = 1'b1;
         return;
      end
      if (pv_taken == 0) begin
         pv_active = pv_version;
         load_chain();
      end
      if (pv_taken < len) begin
         absorb_byte(b, len);
         pv_taken++;
      end
      if (last) begin
         close_name(len, r);
         got = 1'b1;
      end
   endtask

   function automatic bit idle_now();
      return !no_idle && ($urandom_range(99) < 22);
   endfunction

   // drive one transaction and hold it until accepted; fixed rows override the prediction
   task automatic send_byte(input logic [7:0] b, input logic [7:0] len, input logic last,
                            input bit fixed = 1'b0, input result_type fixed_r = '0);
      bit         got;
      result_type r;
      while (idle_now()) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push        <= 1'b1;
      req_name_byte   <= b;
      req_name_length <= len;
      req_last_byte   <= last;
      do @(posedge clock); while (req_full);
      predict_hash(b, len, last, got, r);
      if (got) begin
         hash_q.push_back(fixed ? fixed_r : r);
         names_sent++;
      end
      bytes_sent++;
   endtask

   // drop push, wait for every pending hash, then program all registers
   task automatic program_regs(input logic [2:0] ver, input logic [31:0] s0,
                               input logic [31:0] s1, input logic [31:0] s2,
                               input logic [31:0] s3);
      logic [31:0] vals [5];
      vals[0] = {29'd0, ver};
      vals[1] = s0;
      vals[2] = s1;
      vals[3] = s2;
      vals[4] = s3;
      req_push <= 1'b0;
      @(posedge clock);
      while (hash_q.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      for (int i = 0; i < 5; i++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= 3'(i);
         csr_write_data   <= vals[i];
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
      pv_version = ver;
      for (int i = 0; i < 4; i++) pv_seed[i] = vals[i + 1];
   endtask

   function automatic logic [31:0] pick_seed_word();
      case ($urandom_range(3))
         0:       return 32'd0;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   task automatic send_random_name();
      int mode, len, n;
      mode = $urandom_range(99);
      len  = ($urandom_range(19) == 0) ? $urandom_range(255, 200) : $urandom_range(40, 1);
      if (mode < 85) begin
         for (int i = 0; i < len; i++) send_byte(8'($urandom()), 8'(len), i == len - 1);
      end else if (mode < 89) begin
         // empty name, whatever the end flag says
         send_byte(8'($urandom()), 8'd0, 1'($urandom_range(1)));
      end else if (mode < 93) begin
         n = $urandom_range(len, 1);
         for (int i = 0; i < n; i++) send_byte(8'($urandom()), 8'(len), i == n - 1);
      end else if (mode < 97) begin
         n = len + $urandom_range(6, 1);
         for (int i = 0; i < n; i++) send_byte(8'($urandom()), 8'(len), i == n - 1);
      end else begin
         // length changes from byte to byte
         n = $urandom_range(40, 1);
         for (int i = 0; i < n; i++)
            send_byte(8'($urandom()), 8'($urandom_range(255, 1)), i == n - 1);
      end
   endtask

   // directed rows
   typedef struct {
      logic [2:0]  ver;
      int          seed_sel;
      logic [7:0]  b;
      logic [7:0]  len;
      logic        last;
      bit          fixed;
      result_type  r;
   } dir_row_type;

   dir_row_type dir_rows[$];

   task automatic add_row(input logic [2:0] ver, input int seed_sel, input logic [7:0] b,
                          input logic [7:0] len, input logic last, input bit fixed = 1'b0,
                          input logic [31:0] maj = 0, input logic [31:0] mnr = 0,
                          input logic st = 0);
      dir_row_type row;
      row.ver      = ver;
      row.seed_sel = seed_sel;
      row.b        = b;
      row.len      = len;
      row.last     = last;
      row.fixed    = fixed;
      row.r        = '{major_hash: maj, minor_digest: mnr, status: st};
      dir_rows.push_back(row);
   endtask

   // result side: pop at random, compare each transaction with the oldest pending hash
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            if (hash_q.size() == 0) begin
               $display("%0t unexpected hash: expected none actual %h %h %b", $time,
                        rsp_major_hash, rsp_minor_digest, rsp_status);
               error_count++;
            end else begin
               if (rsp_major_hash !== hash_q[0].major_hash) begin
                  $display("%0t major_hash mismatch: expected %h actual %h", $time,
                           hash_q[0].major_hash, rsp_major_hash);
                  error_count++;
               end
               if (rsp_minor_digest !== hash_q[0].minor_digest) begin
                  $display("%0t minor digest mismatch: expected %h actual %h", $time,
                           hash_q[0].minor_digest, rsp_minor_digest);
                  error_count++;
               end
               if (rsp_status !== hash_q[0].status) begin
                  $display("%0t status mismatch: expected %b actual %b", $time,
                           hash_q[0].status, rsp_status);
                  error_count++;
               end
               void'(hash_q.pop_front());
            end
            hashes_seen++;
         end
         rsp_pop <= !idle_now();
      end
   end

   // hard stop in case the handshake hangs
   initial begin
      #3_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      int          cur_ver, cur_sel, phase, phase_bytes;
      logic [31:0] sv [4];
      error_count      = 0;
      names_sent       = 0;
      bytes_sent       = 0;
      hashes_seen      = 0;
      no_idle          = 1'b0;
      reset            = 1'b1;
      req_push         = 1'b0;
      req_name_byte    = 8'd0;
      req_name_length  = 8'd0;
      req_last_byte    = 1'b0;
      rsp_pop          = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_VERSION;
      csr_write_data   = 32'd0;

      // predictor after reset
      pv_version = VER_RESET;
      pv_active  = VER_RESET;
      for (int i = 0; i < 4; i++) pv_seed[i] = 32'd0;
      for (int i = 0; i < 8; i++) pv_block[i] = 32'd0;
      clear_name();
      load_chain();

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset registers: empty name under default half-MD4
      add_row(3'd1, 0, 8'h00, 8'd0, 1'b1);
      // empty legacy name is the doubled initial value
      add_row(3'd0, 0, 8'hFF, 8'd0, 1'b0, 1'b1, LEG_INIT_CUR << 1, 32'd0, 1'b0);
      add_row(3'd0, 0, 8'hFF, 8'd1, 1'b1);
      add_row(3'd3, 0, 8'hFF, 8'd1, 1'b1);
      // invalid versions: early end and empty name both report the error
      add_row(3'd6, 0, 8'h00, 8'd3, 1'b0);
      add_row(3'd6, 0, 8'h80, 8'd3, 1'b1, 1'b1, 32'd0, 32'd0, 1'b1);
      add_row(3'd7, 0, 8'h55, 8'd0, 1'b1, 1'b1, 32'd0, 32'd0, 1'b1);
      add_row(3'd2, 0, 8'h80, 8'd1, 1'b1);
      add_row(3'd5, 0, 8'h80, 8'd1, 1'b1);
      // early end of a maximum length name
      add_row(3'd4, 0, 8'hFF, 8'd255, 1'b0);
      add_row(3'd4, 0, 8'h00, 8'd255, 1'b1);
      // all-ones seed, one byte past the length is ignored
      add_row(3'd1, 1, 8'h41, 8'd2, 1'b0);
      add_row(3'd1, 1, 8'h42, 8'd2, 1'b0);
      add_row(3'd1, 1, 8'h43, 8'd2, 1'b1);
      add_row(3'd2, 2, 8'h7F, 8'd3, 1'b0);
      add_row(3'd2, 2, 8'h01, 8'd3, 1'b0);
      add_row(3'd2, 2, 8'hFE, 8'd3, 1'b1);
      add_row(3'd0, 1, 8'h00, 8'd0, 1'b1);

      cur_ver = -1;
      cur_sel = -1;
      foreach (dir_rows[i]) begin
         if (dir_rows[i].ver != cur_ver || dir_rows[i].seed_sel != cur_sel) begin
            case (dir_rows[i].seed_sel)
               0: program_regs(dir_rows[i].ver, 0, 0, 0, 0);
               1: program_regs(dir_rows[i].ver, '1, '1, '1, '1);
               default: program_regs(dir_rows[i].ver, 32'h0123_4567, 32'h89AB_CDEF,
                                     32'hFEDC_BA98, 32'h7654_3210);
            endcase
            cur_ver = dir_rows[i].ver;
            cur_sel = dir_rows[i].seed_sel;
         end
         send_byte(dir_rows[i].b, dir_rows[i].len, dir_rows[i].last,
                   dir_rows[i].fixed, dir_rows[i].r);
      end

      // random phases, each under fresh register values; a few phases never idle
      phase = 0;
      bytes_sent = 0;
      while (bytes_sent < 1300) begin
         no_idle = (phase >= 8 && phase < 12);
         for (int i = 0; i < 4; i++) sv[i] = pick_seed_word();
         program_regs(3'((phase < 8) ? phase : $urandom_range(7)), sv[0], sv[1], sv[2], sv[3]);
         phase_bytes = bytes_sent + 50;
         while (bytes_sent < phase_bytes) send_random_name();
         phase++;
      end
      no_idle = 1'b0;
      req_push <= 1'b0;

      // drain remaining hashes, then let the pipeline settle
      while (hash_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      $display("Covered %0d random bytes over %0d phases, %0d hashes compared.",
               bytes_sent, phase, hashes_seen);
      $display("Versions 0-7, zero, all-ones and random seeds, empty/early/excess names.");
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
